### src/mrlb_pkg.sv
`timescale 1ns / 1ps
// Package for the minimum-raggedness line breaker.
// Holds the sizes, cost constants and the controller/datapath command and status types.
package mrlb_pkg;

  localparam int MAX_WORDS = 64;
  localparam int IDX_W     = $clog2(MAX_WORDS);
  localparam int CNT_W     = $clog2(MAX_WORDS + 1);

  localparam int WORD_W    = 10;
  localparam int WIDTH_W   = 10;
  localparam int LEN_W     = 16;
  localparam int START_W   = 6;
  localparam int WORDS_W   = 7;
  localparam int SQ_W      = 2 * WIDTH_W;
  localparam int COST_W    = 33;

  localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(72);
  localparam logic [COST_W-1:0]  COST_INF    = {COST_W{1'b1}};

  typedef struct packed {
    logic             issue;
    logic             first;
    logic             at_end;
    logic             write;
    logic             wr_word;
    logic             load_out;
    logic [CNT_W-1:0] addr;
    logic [CNT_W-1:0] n;
  } cmd_t;

  typedef struct packed {
    logic             out_free;
    logic [CNT_W-1:0] brk;
  } sts_t;

endpackage

### src/mrlb_if.sv
`timescale 1ns / 1ps
// Channel interfaces of the line breaker: word input, line output, width config.
// Depends on mrlb_pkg for the field widths.
interface mrlb_word_if;
  logic                        valid;
  logic                        ready;
  logic [mrlb_pkg::WORD_W-1:0] word_len;
  logic                        last_word;
  modport source (output valid, word_len, last_word, input ready);
  modport sink (input valid, word_len, last_word, output ready);
endinterface

interface mrlb_line_if;
  logic                         valid;
  logic                         ready;
  logic [mrlb_pkg::START_W-1:0] line_start;
  logic [mrlb_pkg::WORDS_W-1:0] line_words;
  logic [mrlb_pkg::LEN_W-1:0]   line_length;
  logic                         overlong;
  logic                         last_line;
  modport source (output valid, line_start, line_words, line_length, overlong, last_line,
                  input ready);
  modport sink (input valid, line_start, line_words, line_length, overlong, last_line,
                output ready);
endinterface

interface mrlb_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [mrlb_pkg::WIDTH_W-1:0] line_width;
  modport source (output valid, line_width, input ready);
  modport sink (input valid, line_width, output ready);
endinterface

### src/min_raggedness_line_breaker.sv
`timescale 1ns / 1ps
// Top level of the minimum-raggedness line breaker.
// Depends on mrlb_pkg, the channel interfaces, mrlb_ctrl and mrlb_dp.

// Words of a paragraph are taken one per cycle as lengths; words beyond 64 are
// dropped. When the word flagged as last is taken, the block stops taking words
// and searches the breaks that minimize the summed squared slack of all lines,
// ties going to the shortest first line. The search runs one candidate line per
// cycle through a four-stage cost pipeline, and the pipeline is drained before
// each stored word's best cost is written back. Lines then leave from an output
// register, each loaded after its break is read and held back while the sink
// stalls, and words of the next paragraph are taken as soon as the final line
// sits in that register. The width register is to be written only while the
// block is idle; the block itself does not enforce this.
module min_raggedness_line_breaker (
  input  logic              clk,
  input  logic              rst,
  mrlb_word_if.sink         word_in,
  mrlb_line_if.source       line_out,
  mrlb_cfg_if.sink          cfg
);

  mrlb_pkg::cmd_t cmd;
  mrlb_pkg::sts_t sts;

  assign cfg.ready = 1'b1;

  mrlb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (word_in.valid),
    .in_last  (word_in.last_word),
    .in_ready (word_in.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mrlb_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .word_len    (word_in.word_len),
    .cfg_valid   (cfg.valid),
    .cfg_width   (cfg.line_width),
    .out_valid   (line_out.valid),
    .out_ready   (line_out.ready),
    .line_start  (line_out.line_start),
    .line_words  (line_out.line_words),
    .line_length (line_out.line_length),
    .overlong    (line_out.overlong),
    .last_line   (line_out.last_line)
  );

endmodule

### src/mrlb_ctrl.sv
`timescale 1ns / 1ps
// Controller of the line breaker: word loading, break search sequencing, line emission.
// Depends on mrlb_pkg for sizes and the command and status types.
module mrlb_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_last,
  output logic                       in_ready,
  input  mrlb_pkg::sts_t             sts,
  output mrlb_pkg::cmd_t             cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROW,
    S_DRAIN,
    S_WRITE,
    S_EMIT_RD,
    S_EMIT_SET
  } state_t;

  state_t                     state;
  logic [mrlb_pkg::CNT_W-1:0] count;
  logic [mrlb_pkg::CNT_W-1:0] n;
  logic [mrlb_pkg::CNT_W-1:0] i;
  logic [mrlb_pkg::CNT_W-1:0] j;
  logic [1:0]                 drain;
  logic                       room;
  logic [mrlb_pkg::CNT_W-1:0] count_next;

  assign room       = count < mrlb_pkg::CNT_W'(mrlb_pkg::MAX_WORDS);
  assign count_next = room ? count + mrlb_pkg::CNT_W'(1) : count;
  assign in_ready   = (state == S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.n        = n;
    cmd.issue    = (state == S_ROW);
    cmd.first    = (j == i);
    cmd.at_end   = (j + mrlb_pkg::CNT_W'(1) == n);
    cmd.write    = (state == S_WRITE);
    cmd.wr_word  = (state == S_IDLE) && in_valid && room;
    cmd.load_out = (state == S_EMIT_SET) && sts.out_free;
    unique case (state)
      S_IDLE:  cmd.addr = count;
      S_ROW:   cmd.addr = j;
      default: cmd.addr = i;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      n     <= '0;
      i     <= '0;
      j     <= '0;
      drain <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            count <= count_next;
            if (in_last) begin
              n     <= count_next;
              i     <= count_next - mrlb_pkg::CNT_W'(1);
              j     <= count_next - mrlb_pkg::CNT_W'(1);
              state <= S_ROW;
            end
          end
        end
        S_ROW: begin
          j <= j + mrlb_pkg::CNT_W'(1);
          if (j + mrlb_pkg::CNT_W'(1) == n) begin
            drain <= '0;
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          drain <= drain + 2'd1;
          if (drain == 2'd2) begin
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          if (i == '0) begin
            state <= S_EMIT_RD;
          end else begin
            i     <= i - mrlb_pkg::CNT_W'(1);
            j     <= i - mrlb_pkg::CNT_W'(1);
            state <= S_ROW;
          end
        end
        S_EMIT_RD: begin
          state <= S_EMIT_SET;
        end
        S_EMIT_SET: begin
          if (sts.out_free) begin
            if (sts.brk == n) begin
              count <= '0;
              state <= S_IDLE;
            end else begin
              i     <= sts.brk;
              state <= S_EMIT_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### src/mrlb_dp.sv
`timescale 1ns / 1ps
// Datapath of the line breaker: word, cost and break memories, the cost pipeline
// and the output register. Depends on mrlb_pkg and is driven by mrlb_ctrl.
module mrlb_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  mrlb_pkg::cmd_t                cmd,
  output mrlb_pkg::sts_t                sts,
  input  logic [mrlb_pkg::WORD_W-1:0]   word_len,
  input  logic                          cfg_valid,
  input  logic [mrlb_pkg::WIDTH_W-1:0]  cfg_width,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mrlb_pkg::START_W-1:0]  line_start,
  output logic [mrlb_pkg::WORDS_W-1:0]  line_words,
  output logic [mrlb_pkg::LEN_W-1:0]    line_length,
  output logic                          overlong,
  output logic                          last_line
);

  logic [mrlb_pkg::WORD_W-1:0]  word_mem [mrlb_pkg::MAX_WORDS];
  logic [mrlb_pkg::COST_W-1:0]  best_mem [mrlb_pkg::MAX_WORDS + 1];
  logic [mrlb_pkg::CNT_W-1:0]   brk_mem  [mrlb_pkg::MAX_WORDS];
  logic [mrlb_pkg::LEN_W-1:0]   blen_mem [mrlb_pkg::MAX_WORDS];

  logic [mrlb_pkg::WIDTH_W-1:0] line_width;

  logic                         s1_valid;
  logic                         s1_first;
  logic                         s1_end;
  logic [mrlb_pkg::CNT_W-1:0]   s1_j;
  logic [mrlb_pkg::WORD_W-1:0]  s1_wl;
  logic [mrlb_pkg::COST_W-1:0]  s1_bc;
  logic [mrlb_pkg::LEN_W-1:0]   len_acc;
  logic [mrlb_pkg::LEN_W-1:0]   len_next;

  logic                         s2_valid;
  logic                         s2_first;
  logic [mrlb_pkg::CNT_W-1:0]   s2_j;
  logic [mrlb_pkg::LEN_W-1:0]   s2_len;
  logic [mrlb_pkg::COST_W-1:0]  s2_bc;
  logic                         s2_over;
  logic [mrlb_pkg::WIDTH_W-1:0] s2_slack;

  logic                         s3_valid;
  logic                         s3_first;
  logic [mrlb_pkg::CNT_W-1:0]   s3_j;
  logic [mrlb_pkg::LEN_W-1:0]   s3_len;
  logic [mrlb_pkg::COST_W-1:0]  s3_bc;
  logic                         s3_over;
  logic [mrlb_pkg::SQ_W-1:0]    s3_sq;
  logic [mrlb_pkg::COST_W:0]    sum;
  logic [mrlb_pkg::COST_W-1:0]  total;

  logic [mrlb_pkg::COST_W-1:0]  best_run;
  logic [mrlb_pkg::CNT_W-1:0]   brk_run;
  logic [mrlb_pkg::LEN_W-1:0]   blen_run;

  logic [mrlb_pkg::CNT_W-1:0]   brk_q;
  logic [mrlb_pkg::LEN_W-1:0]   blen_q;
  logic [mrlb_pkg::CNT_W-1:0]   best_addr;

  assign best_addr = cmd.addr + mrlb_pkg::CNT_W'(1);
  assign sts.out_free = !out_valid || out_ready;
  assign sts.brk      = brk_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= mrlb_pkg::WIDTH_RESET;
    end else if (cfg_valid) begin
      line_width <= cfg_width;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_word) begin
      word_mem[cmd.addr[mrlb_pkg::IDX_W-1:0]] <= word_len;
    end
    if (cmd.write) begin
      best_mem[cmd.addr] <= best_run;
      brk_mem[cmd.addr[mrlb_pkg::IDX_W-1:0]]  <= brk_run;
      blen_mem[cmd.addr[mrlb_pkg::IDX_W-1:0]] <= blen_run;
    end
    s1_wl  <= word_mem[cmd.addr[mrlb_pkg::IDX_W-1:0]];
    s1_bc  <= best_mem[best_addr];
    brk_q  <= brk_mem[cmd.addr[mrlb_pkg::IDX_W-1:0]];
    blen_q <= blen_mem[cmd.addr[mrlb_pkg::IDX_W-1:0]];
  end

  // Stage one extends the running line length by one space and the next word, or starts it at the word alone.
  assign len_next = (s1_first ? '0 : len_acc + mrlb_pkg::LEN_W'(1))
                  + mrlb_pkg::LEN_W'(s1_wl);

  // Stage three adds the line cost to the best cost of the rest, saturating; an overlong line costs the maximum.
  assign sum   = (mrlb_pkg::COST_W + 1)'(s3_sq) + {1'b0, s3_bc};
  assign total = (s3_over || sum >= {1'b0, mrlb_pkg::COST_INF}) ? mrlb_pkg::COST_INF
               : sum[mrlb_pkg::COST_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.issue;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
    s1_first <= cmd.first;
    s1_end   <= cmd.at_end;
    s1_j     <= cmd.addr;

    if (s1_valid) begin
      len_acc <= len_next;
    end
    s2_first <= s1_first;
    s2_j     <= s1_j;
    s2_len   <= len_next;
    s2_bc    <= s1_end ? '0 : s1_bc;

    s3_first <= s2_first;
    s3_j     <= s2_j;
    s3_len   <= s2_len;
    s3_bc    <= s2_bc;
    s3_over  <= s2_over;
    s3_sq    <= s2_slack * s2_slack;

    if (s3_valid && (s3_first || total < best_run)) begin
      best_run <= total;
      brk_run  <= s3_j + mrlb_pkg::CNT_W'(1);
      blen_run <= s3_len;
    end
  end

  always_comb begin
    s2_over  = s2_len > mrlb_pkg::LEN_W'(line_width);
    s2_slack = line_width - s2_len[mrlb_pkg::WIDTH_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.load_out) begin
      line_start  <= mrlb_pkg::START_W'(cmd.addr);
      line_words  <= mrlb_pkg::WORDS_W'(brk_q - cmd.addr);
      line_length <= blen_q;
      overlong    <= blen_q > mrlb_pkg::LEN_W'(line_width);
      last_line   <= (brk_q == cmd.n);
    end
  end

endmodule
